[src/sgt_pkg.sv]
package sgt_pkg;

   localparam int WINDOW    = 256;
   localparam int WIN_IDX_W = $clog2(WINDOW);

   typedef logic [WINDOW-1:0]    lost_map_type;
   typedef logic [WIN_IDX_W-1:0] win_idx_type;

   typedef enum logic [1:0] {
      VERDICT_IN_ORDER  = 2'd0,
      VERDICT_DISCARD   = 2'd1,
      VERDICT_GAP       = 2'd2,
      VERDICT_RECOVERED = 2'd3
   } verdict_type;

   typedef enum logic [2:0] {
      OP_DISCARD,
      OP_FIRST,
      OP_NEXT,
      OP_GAP,
      OP_RECOVER
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic commit;
   } cmd_type;

endpackage

[src/sgt_req_if.sv]
interface sgt_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] seq_num;

   modport source (output valid, output kind, output seq_num, input ready);
   modport sink (input valid, input kind, input seq_num, output ready);
endinterface

[src/sgt_rsp_if.sv]
interface sgt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic [31:0] gap_first;
   logic        gap_overflow;

   modport source (output valid, output verdict, output gap_first, output gap_overflow,
                   input ready);
   modport sink (input valid, input verdict, input gap_first, input gap_overflow,
                 output ready);
endinterface

[src/sgt_ctrl.sv]
module sgt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sgt_pkg::cmd_type cmd
);

   sgt_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sgt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         sgt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sgt_pkg::ST_DECODE;
            end
         end
         sgt_pkg::ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = sgt_pkg::ST_COMMIT;
         end
         sgt_pkg::ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = sgt_pkg::ST_IDLE;
            end
         end
         default: state_in = sgt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a new result never overwrites one still waiting
   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten");

   // decode always leads straight to commit
   a_decode_then_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.decode |=> state_ff == sgt_pkg::ST_COMMIT)
      else $error("decode not followed by commit");

endmodule

[src/sgt_datapath.sv]
module sgt_datapath (
   input  logic             clock,
   input  logic             reset,
   input  sgt_pkg::cmd_type cmd,
   input  logic             req_kind,
   input  logic [31:0]      req_seq_num,
   output logic [1:0]       rsp_verdict,
   output logic [31:0]      rsp_gap_first,
   output logic             rsp_gap_overflow
);

   // captured transaction
   logic        kind_ff;
   logic [31:0] seq_ff;

   // tracker state
   logic [31:0]           latest_ff, latest_in;
   logic                  seen_ff, seen_in;
   sgt_pkg::lost_map_type lost_ff, lost_in;

   // decoded operation
   sgt_pkg::op_type      op_ff, op_in;
   logic                 clr_all_ff, clr_all_in;
   logic                 mark_all_ff, mark_all_in;
   logic                 ovf_ff, ovf_in;
   sgt_pkg::win_idx_type shamt_ff, shamt_in;
   sgt_pkg::win_idx_type mark_cnt_ff, mark_cnt_in;
   sgt_pkg::win_idx_type off_ff, off_in;

   // result registers
   sgt_pkg::verdict_type verdict_ff, verdict_in;
   logic [31:0]          gap_first_ff, gap_first_in;
   logic                 gap_ovf_ff, gap_ovf_in;

   logic [31:0]           off_full, delta, skipped;
   logic                  hit;
   sgt_pkg::lost_map_type ones, shifted, mark_mask;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         seq_ff  <= req_seq_num;
      end
   end

   // decode
   always_comb begin
      off_full    = latest_ff - 32'd1 - seq_ff;
      delta       = seq_ff - latest_ff;
      skipped     = delta - 32'd1;
      hit         = seen_ff && (seq_ff < latest_ff) && (off_full < 32'(sgt_pkg::WINDOW))
                    && lost_ff[off_full[sgt_pkg::WIN_IDX_W-1:0]];
      off_in      = off_full[sgt_pkg::WIN_IDX_W-1:0];
      shamt_in    = delta[sgt_pkg::WIN_IDX_W-1:0];
      mark_cnt_in = skipped[sgt_pkg::WIN_IDX_W-1:0];
      clr_all_in  = delta >= 32'(sgt_pkg::WINDOW);
      mark_all_in = skipped >= 32'(sgt_pkg::WINDOW);
      ovf_in      = skipped > 32'(sgt_pkg::WINDOW);
      if (kind_ff) begin
         op_in = hit ? sgt_pkg::OP_RECOVER : sgt_pkg::OP_DISCARD;
      end else if (!seen_ff) begin
         op_in = sgt_pkg::OP_FIRST;
      end else if (seq_ff == latest_ff + 32'd1) begin
         op_in = sgt_pkg::OP_NEXT;
      end else if (seq_ff == latest_ff) begin
         op_in = sgt_pkg::OP_DISCARD;
      end else if (seq_ff < latest_ff) begin
         op_in = hit ? sgt_pkg::OP_RECOVER : sgt_pkg::OP_DISCARD;
      end else begin
         op_in = sgt_pkg::OP_GAP;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         op_ff       <= op_in;
         clr_all_ff  <= clr_all_in;
         mark_all_ff <= mark_all_in;
         ovf_ff      <= ovf_in;
         shamt_ff    <= shamt_in;
         mark_cnt_ff <= mark_cnt_in;
         off_ff      <= off_in;
      end
   end

   // commit
   always_comb begin
      ones         = '1;
      shifted      = clr_all_ff ? '0 : (lost_ff << shamt_ff);
      mark_mask    = mark_all_ff ? ones : ~(ones << mark_cnt_ff);
      latest_in    = latest_ff;
      seen_in      = seen_ff;
      lost_in      = lost_ff;
      verdict_in   = sgt_pkg::VERDICT_DISCARD;
      gap_first_in = '0;
      gap_ovf_in   = 1'b0;
      case (op_ff)
         sgt_pkg::OP_FIRST: begin
            seen_in    = 1'b1;
            latest_in  = seq_ff;
            verdict_in = sgt_pkg::VERDICT_IN_ORDER;
         end
         sgt_pkg::OP_NEXT: begin
            latest_in  = seq_ff;
            lost_in    = lost_ff << 1;
            verdict_in = sgt_pkg::VERDICT_IN_ORDER;
         end
         sgt_pkg::OP_GAP: begin
            latest_in    = seq_ff;
            lost_in      = shifted | mark_mask;
            verdict_in   = sgt_pkg::VERDICT_GAP;
            gap_first_in = latest_ff + 32'd1;
            gap_ovf_in   = ovf_ff;
         end
         sgt_pkg::OP_RECOVER: begin
            lost_in[off_ff] = 1'b0;
            verdict_in      = sgt_pkg::VERDICT_RECOVERED;
         end
         default: verdict_in = sgt_pkg::VERDICT_DISCARD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latest_ff <= '0;
         seen_ff   <= 1'b0;
         lost_ff   <= '0;
      end else if (cmd.commit) begin
         latest_ff <= latest_in;
         seen_ff   <= seen_in;
         lost_ff   <= lost_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         verdict_ff   <= verdict_in;
         gap_first_ff <= gap_first_in;
         gap_ovf_ff   <= gap_ovf_in;
      end
   end

   assign rsp_verdict      = verdict_ff;
   assign rsp_gap_first    = gap_first_ff;
   assign rsp_gap_overflow = gap_ovf_ff;

   // a recovered number is cleared from the window
   a_recover_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == sgt_pkg::OP_RECOVER) |=> !lost_ff[$past(off_ff)])
      else $error("recovered entry still marked lost");

   // once a feed packet is seen the flag stays set
   a_seen_sticky: assert property (@(posedge clock) disable iff (reset)
      seen_ff |=> seen_ff)
      else $error("seen flag dropped");

endmodule

[src/sequence_gap_tracker.sv]
// Sequence gap tracker: takes one packet (live feed or replay) per transaction and returns
// one verdict: in order, discard, accept after gap (with the first missing number and an
// overflow flag when the gap is wider than the 256-entry loss window) or recovered lost.
// Each packet goes through the capture, decode and commit steps set by the controller
// sequence, and its verdict is presented from the output register after its commit;
// a new packet is accepted while the previous result still waits in the output register,
// and the commit waits until that result is taken. The loss bitmap is held in flip-flops
// and cleared at reset.
module sequence_gap_tracker (
   input logic      clock,
   input logic      reset,
   sgt_req_if.sink  req_ch,
   sgt_rsp_if.source rsp_ch
);

   sgt_pkg::cmd_type cmd;

   sgt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   sgt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_kind         (req_ch.kind),
      .req_seq_num      (req_ch.seq_num),
      .rsp_verdict      (rsp_ch.verdict),
      .rsp_gap_first    (rsp_ch.gap_first),
      .rsp_gap_overflow (rsp_ch.gap_overflow)
   );

endmodule
